/* rtl/qct_pkg.sv */
// Package: token kinds, scan modes, keyword lookup and beat types for the tokenizer.
package qct_pkg;

	localparam int MaxTextBytes = 65536;
	localparam int KwMaxChars = 10;
	localparam int PosW = $clog2(MaxTextBytes) + 1;
	localparam logic [15:0] LenMax = 16'hFFFF;

	localparam logic [2:0] K_KEYWORD = 3'd0;
	localparam logic [2:0] K_NAME = 3'd1;
	localparam logic [2:0] K_NUMBER = 3'd2;
	localparam logic [2:0] K_STRING = 3'd3;
	localparam logic [2:0] K_CHAR = 3'd4;
	localparam logic [2:0] K_END = 3'd5;
	localparam logic [2:0] K_ERROR = 3'd6;
	localparam logic [2:0] K_DONE = 3'd7;

	typedef enum logic [2:0] {
		M_IDLE, M_WORD, M_STR, M_CH_FIRST, M_CH_ESC, M_CH_CLOSE
	} mode_t;

	typedef struct packed {
		logic [7:0] text_byte;
		logic end_of_text;
	} in_beat_t;

	typedef struct packed {
		logic [2:0] token_kind;
		logic [5:0] keyword_code;
		logic [15:0] token_start;
		logic [15:0] token_length;
		logic [7:0] char_value;
		logic last_of_run;
	} out_beat_t;

	typedef logic [KwMaxChars*8-1:0] kw_chars_t;

	// word lookup: returns {hit, kind_is_string, code}
	function automatic logic [7:0] kw_lookup(input kw_chars_t w, input logic [15:0] len);
		logic [7:0] r;
		logic [79:0] s;
		r = 8'd0;
		s = w[79:0];
		// bytes stored little-end first: byte i at [8i+7:8i]
		case (len)
			16'd2: case (s[15:0])
				{"1","i"}: r = {2'b10, 6'd31};
				{"2","i"}: r = {2'b10, 6'd32};
				{"4","i"}: r = {2'b10, 6'd33};
				{"8","i"}: r = {2'b10, 6'd34};
				{"4","f"}: r = {2'b10, 6'd39};
				{"8","f"}: r = {2'b10, 6'd40};
				{"T","A"}: r = {2'b10, 6'd52};
				{"O","T"}: r = {2'b10, 6'd53};
				default: r = 8'd0;
			endcase
			16'd3: case (s[23:0])
				{"1","i","u"}: r = {2'b10, 6'd35};
				{"2","i","u"}: r = {2'b10, 6'd36};
				{"4","i","u"}: r = {2'b10, 6'd37};
				{"8","i","u"}: r = {2'b10, 6'd38};
				{"Y","E","K"}: r = {2'b10, 6'd1};
				{"L","E","D"}: r = {2'b10, 6'd7};
				{"T","E","G"}: r = {2'b10, 6'd8};
				{"T","E","S"}: r = {2'b10, 6'd15};
				{"D","D","A"}: r = {2'b10, 6'd16};
				{"L","L","A"}: r = {2'b10, 6'd27};
				default: r = 8'd0;
			endcase
			16'd4: case (s[31:0])
				{"M","O","R","F"}: r = {2'b10, 6'd54};
				{"E","P","Y","T"}: r = {2'b10, 6'd29};
				{"K","O","O","H"}: r = {2'b10, 6'd0};
				{"T","S","I","L"}: r = {2'b10, 6'd4};
				{"P","A","W","S"}: r = {2'b10, 6'd14};
				{"R","C","N","I"}: r = {2'b10, 6'd17};
				{"R","C","E","D"}: r = {2'b10, 6'd18};
				{"P","O","P","L"}: r = {2'b10, 6'd19};
				{"P","O","P","R"}: r = {2'b10, 6'd20};
				{"C","S","E","D"}: r = {2'b10, 6'd26};
				{"1","1","2","d"}: r = {2'b10, 6'd41};
				{"1","1","1","t"}: r = {2'b10, 6'd42};
				{"Y","E","K","P"}: r = {2'b10, 6'd44};
				{"Y","E","K","F"}: r = {2'b10, 6'd45};
				{"K","N","A","R"}: r = {2'b10, 6'd51};
				{"e","m","i","t"}: r = {2'b10, 6'd42};
				{"e","t","a","d"}: r = {2'b10, 6'd41};
				default: r = 8'd0;
			endcase
			16'd5: case (s[39:0])
				{"E","L","B","A","T"}: r = {2'b10, 6'd2};
				{"T","N","U","O","C"}: r = {2'b10, 6'd24};
				{"R","A","E","L","C"}: r = {2'b10, 6'd10};
				{"E","R","E","H","W"}: r = {2'b10, 6'd28};
				{"H","S","U","P","L"}: r = {2'b10, 6'd21};
				{"H","S","U","P","R"}: r = {2'b10, 6'd22};
				{"D","L","E","I","F"}: r = {2'b10, 6'd50};
				{"t","a","o","l","f"}: r = {2'b10, 6'd39};
				default: r = 8'd0;
			endcase
			16'd6: case (s[47:0])
				{"P","A","M","T","I","B"}: r = {2'b10, 6'd5};
				{"M","A","E","R","T","S"}: r = {2'b10, 6'd6};
				{"S","T","S","I","X","E"}: r = {2'b10, 6'd30};
				{"T","C","E","L","E","S"}: r = {2'b10, 6'd13};
				{"E","T","A","D","P","U"}: r = {2'b10, 6'd12};
				{"D","N","E","P","P","A"}: r = {2'b10, 6'd23};
				{"E","U","Q","I","N","U"}: r = {2'b10, 6'd46};
				{"T","O","L","A","V","K"}: r = {2'b10, 6'd3};
				{"T","R","E","S","N","I"}: r = {2'b10, 6'd11};
				{"E","M","A","N","E","R"}: r = {2'b10, 6'd9};
				{"t","_","8","t","n","i"}: r = {2'b10, 6'd31};
				{"e","l","b","u","o","d"}: r = {2'b10, 6'd40};
				{"m","a","e","r","t","s"}: r = {2'b11, 6'd0};
				default: r = 8'd0;
			endcase
			16'd7: case (s[55:0])
				{"T","L","U","A","F","E","D"}: r = {2'b10, 6'd48};
				{"L","L","U","N","T","O","N"}: r = {2'b10, 6'd47};
				{"t","_","8","t","n","i","u"}: r = {2'b10, 6'd35};
				{"t","_","6","1","t","n","i"}: r = {2'b10, 6'd32};
				{"t","_","2","3","t","n","i"}: r = {2'b10, 6'd33};
				{"t","_","4","6","t","n","i"}: r = {2'b10, 6'd34};
				default: r = 8'd0;
			endcase
			16'd8: case (s[63:0])
				{"1","1","1","1","1","2","t","d"}: r = {2'b10, 6'd43};
				{"t","_","6","1","t","n","i","u"}: r = {2'b10, 6'd36};
				{"t","_","2","3","t","n","i","u"}: r = {2'b10, 6'd37};
				{"t","_","4","6","t","n","i","u"}: r = {2'b10, 6'd38};
				{"e","m","i","t","e","t","a","d"}: r = {2'b10, 6'd43};
				default: r = 8'd0;
			endcase
			16'd9: if (s[71:0] == {"E","T","U","B","I","R","T","T","A"})
				r = {2'b10, 6'd49};
			16'd10: if (s == {"E","T","A","N","I","D","R","O","O","C"})
				r = {2'b10, 6'd25};
			default: r = 8'd0;
		endcase
		return r;
	endfunction

endpackage

/* rtl/qct_stream_if.sv */
// Valid/ready stream interface carrying one payload beat.
interface qct_stream_if #(parameter type payload_t = logic) ();
	logic valid;
	logic ready;
	payload_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

/* rtl/query_command_tokenizer_top.sv */
// Top level of the command text tokenizer.
// channel  dir  payload                                   beat
// in_s     in   text_byte, end_of_text                    one text byte
// out_s    out  kind, code, start, length, char, last     one token descriptor
// One byte is taken per cycle while the queue has room; its results go into an
// 8-deep queue at that edge and reach out_s behind any beats already queued.
// A byte yields up to three results; out_s drains the queue one a cycle while
// ready, so a run of multi-result bytes stalls input below three free slots.
// Asynchronous reset returns the scanner to idle with the queue empty.
module query_command_tokenizer_top (
	input logic clk,
	input logic arst_n,
	qct_stream_if.sink in_s,
	qct_stream_if.source out_s
);
	import qct_pkg::*;

	out_beat_t res [3];
	logic [1:0] res_n;
	logic room, acc;

	assign in_s.ready = room;
	assign acc = in_s.valid && room;

	qct_scan u_scan (
		.clk(clk), .arst_n(arst_n), .en(acc), .in_beat(in_s.data),
		.res(res), .res_n(res_n)
	);

	qct_outq u_q (
		.clk(clk), .arst_n(arst_n), .push(acc), .wr(res), .wr_n(res_n),
		.room(room), .out_s(out_s)
	);
endmodule

/* rtl/qct_scan.sv */
// Scanner core: consumes one byte per beat and produces up to three result beats.
module qct_scan (
	input logic clk,
	input logic arst_n,
	input logic en,
	input qct_pkg::in_beat_t in_beat,
	output qct_pkg::out_beat_t res [3],
	output logic [1:0] res_n
);
	import qct_pkg::*;

	mode_t mode_q;
	logic [PosW-1:0] pos_q;
	logic [15:0] start_q, len_q;
	kw_chars_t kw_q;
	logic dstart_q, numok_q, bsl_q, err_q;
	logic [7:0] lit_q;

	mode_t mode_d;
	logic [PosW-1:0] pos_d;
	logic [15:0] start_d, len_d;
	kw_chars_t kw_d;
	logic dstart_d, numok_d, bsl_d, err_d;
	logic [7:0] lit_d;

	out_beat_t r [3];
	logic [1:0] n;
	logic [7:0] b;
	logic [15:0] pos16;
	logic [7:0] kl;
	logic isdig, isstart, clr;

	function automatic out_beat_t mk(logic [2:0] k, logic [5:0] c, logic [15:0] s,
			logic [15:0] l, logic [7:0] v);
		out_beat_t o;
		o.token_kind = k;
		o.keyword_code = c;
		o.token_start = s;
		o.token_length = l;
		o.char_value = v;
		o.last_of_run = 1'b0;
		return o;
	endfunction

	always_comb begin
		b = in_beat.text_byte;
		pos16 = pos_q[15:0];
		isdig = b >= "0" && b <= "9";
		isstart = (b >= "a" && b <= "z") || (b >= "A" && b <= "Z") || isdig || b[7]
			|| b == "_" || b == 8'h22 || b == 8'h27 || b == ";" || b == 8'h0A;
		kl = kw_lookup(kw_q, len_q);
		mode_d = mode_q; pos_d = pos_q; start_d = start_q; len_d = len_q; kw_d = kw_q;
		dstart_d = dstart_q; numok_d = numok_q; bsl_d = bsl_q; err_d = err_q; lit_d = lit_q;
		r[0] = mk(K_DONE, 6'd0, 16'd0, 16'd0, 8'd0);
		r[1] = r[0]; r[2] = r[0];
		n = 2'd0;
		clr = 1'b0;
		if (err_q) begin
		end else if (pos_q >= PosW'(MaxTextBytes)) begin
			r[0] = mk(K_ERROR, 6'd0, pos16, 16'd0, 8'd0); n = 2'd1;
			err_d = 1'b1; mode_d = M_IDLE; clr = 1'b1;
		end else begin
			case (mode_q)
				M_IDLE: begin
					if (b == ";") begin
						r[0] = mk(K_END, 6'd0, pos16, 16'd0, 8'd0); n = 2'd1;
					end else if (b == 8'h22 || b == 8'h27) begin
						clr = 1'b1;
						mode_d = (b == 8'h22) ? M_STR : M_CH_FIRST;
						start_d = pos16 + 16'd1;
					end else if (isstart) begin
						mode_d = M_WORD;
						start_d = pos16;
						dstart_d = isdig;
						numok_d = isdig || b == ".";
						kw_d = '0;
						kw_d[7:0] = b;
						len_d = 16'd1;
						bsl_d = 1'b0; lit_d = 8'd0;
					end
				end
				M_WORD: begin
					if (b == " " || b == ";") begin
						if (!kl[7] && dstart_q && !numok_q) begin
							r[0] = mk(K_ERROR, 6'd0, start_q, 16'd0, 8'd0); n = 2'd1;
							err_d = 1'b1; mode_d = M_IDLE; clr = 1'b1;
						end else begin
							r[0] = mk(kl[7] ? (kl[6] ? K_STRING : K_KEYWORD)
								: (dstart_q ? K_NUMBER : K_NAME),
								kl[7] ? kl[5:0] : 6'd0, start_q, len_q, 8'd0);
							n = 2'd1; mode_d = M_IDLE; clr = 1'b1;
							if (b == ";") begin
								r[1] = mk(K_END, 6'd0, pos16, 16'd0, 8'd0); n = 2'd2;
							end
						end
					end else begin
						if (!isdig && b != ".") numok_d = 1'b0;
						for (int i = 0; i < KwMaxChars; i++)
							if (len_q == 16'(i)) kw_d[i*8 +: 8] = b;
						if (len_q != LenMax) len_d = len_q + 16'd1;
					end
				end
				M_STR: begin
					if (len_q != 16'd0 && b == 8'h22 && !bsl_q) begin
						r[0] = mk(K_STRING, 6'd0, start_q, len_q, 8'd0); n = 2'd1;
						mode_d = M_IDLE; clr = 1'b1;
					end else begin
						bsl_d = b == 8'h5C;
						if (len_q != LenMax) len_d = len_q + 16'd1;
					end
				end
				M_CH_FIRST: begin
					if (b == 8'h5C) mode_d = M_CH_ESC;
					else begin
						lit_d = b; mode_d = M_CH_CLOSE;
					end
				end
				M_CH_ESC: begin
					mode_d = M_CH_CLOSE;
					case (b)
						"n": lit_d = 8'd10;
						"t": lit_d = 8'd9;
						"r": lit_d = 8'd13;
						"0": lit_d = 8'd0;
						8'h5C: lit_d = 8'd92;
						default: begin
							r[0] = mk(K_ERROR, 6'd0, start_q, 16'd0, 8'd0); n = 2'd1;
							err_d = 1'b1; mode_d = M_IDLE; clr = 1'b1;
						end
					endcase
				end
				default: begin
					if (b == 8'h27)
						r[0] = mk(K_CHAR, 6'd0, start_q, 16'd1, lit_q);
					else begin
						r[0] = mk(K_ERROR, 6'd0, start_q, 16'd0, 8'd0);
						err_d = 1'b1;
					end
					n = 2'd1; mode_d = M_IDLE; clr = 1'b1;
				end
			endcase
			if (in_beat.end_of_text && mode_d != M_IDLE && !err_d) begin
				r[n] = mk(K_ERROR, 6'd0, start_d, 16'd0, 8'd0);
				n = n + 2'd1;
				err_d = 1'b1;
			end
		end
		if (clr) begin
			len_d = 16'd0; kw_d = '0; dstart_d = 1'b0; numok_d = 1'b1;
			bsl_d = 1'b0; lit_d = 8'd0;
		end
		if (pos_q < PosW'(MaxTextBytes)) pos_d = pos_q + PosW'(1);
		if (in_beat.end_of_text) begin
			r[n] = mk(K_DONE, 6'd0, 16'd0, 16'd0, 8'd0);
			n = n + 2'd1;
			mode_d = M_IDLE; pos_d = '0; start_d = 16'd0; err_d = 1'b0;
			len_d = 16'd0; kw_d = '0; dstart_d = 1'b0; numok_d = 1'b1;
			bsl_d = 1'b0; lit_d = 8'd0;
		end
		if (n != 2'd0) r[n - 2'd1].last_of_run = 1'b1;
	end

	assign res = r;
	assign res_n = n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= M_IDLE; pos_q <= '0; start_q <= '0; len_q <= '0; kw_q <= '0;
			dstart_q <= 1'b0; numok_q <= 1'b1; bsl_q <= 1'b0; lit_q <= '0; err_q <= 1'b0;
		end else if (en) begin
			mode_q <= mode_d; pos_q <= pos_d; start_q <= start_d; len_q <= len_d;
			kw_q <= kw_d; dstart_q <= dstart_d; numok_q <= numok_d; bsl_q <= bsl_d;
			lit_q <= lit_d; err_q <= err_d;
		end
	end
endmodule

/* rtl/qct_outq.sv */
// Result queue: takes up to three beats at once and drains one per cycle when out_s is ready.
module qct_outq (
	input logic clk,
	input logic arst_n,
	input logic push,
	input qct_pkg::out_beat_t wr [3],
	input logic [1:0] wr_n,
	output logic room,
	qct_stream_if.source out_s
);
	import qct_pkg::*;

	out_beat_t mem_q [8];
	logic [2:0] rd_q, wr_q;
	logic [3:0] cnt_q;
	logic pop;
	logic [1:0] nadd;

	assign nadd = push ? wr_n : 2'd0;
	assign pop = out_s.valid && out_s.ready;
	assign out_s.valid = cnt_q != 4'd0;
	assign out_s.data = mem_q[rd_q];
	// need space for three beats; a beat draining this cycle is not counted
	assign room = cnt_q <= 4'd5;

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++)
			if (2'(i) < nadd) mem_q[wr_q + 3'(i)] <= wr[i];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q <= '0; wr_q <= '0; cnt_q <= '0;
		end else begin
			wr_q <= wr_q + 3'(nadd);
			if (pop) rd_q <= rd_q + 3'd1;
			cnt_q <= cnt_q + 4'(nadd) - 4'(pop);
		end
	end
endmodule

/* rtl/qct_checker.sv */
// Port-level checker for the tokenizer, bound to the top level.
module qct_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input qct_pkg::out_beat_t out_data
);
	import qct_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("output beat changed while stalled");
	a_in_stall: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_ready |-> out_valid)
		else $error("input stalled with queue empty");
	a_done_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.token_kind == K_DONE |-> out_data.last_of_run)
		else $error("text done not last of run");
	a_end_len: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_data.token_kind == K_END || out_data.token_kind == K_ERROR)
		|-> out_data.token_length == 16'd0)
		else $error("end or error with length");
	a_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.token_kind != K_KEYWORD |-> out_data.keyword_code == 6'd0)
		else $error("code on non-keyword");
endmodule

bind query_command_tokenizer_top qct_checker u_chk (
	.clk(clk), .arst_n(arst_n), .in_valid(in_s.valid), .in_ready(in_s.ready),
	.out_valid(out_s.valid), .out_ready(out_s.ready), .out_data(out_s.data)
);
